FILE: src/nsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types and constants of the NMEA sentence framer: character codes,
// event codes, register indexes and the item structs between the parts.
// ----------------------------------------------------------------------------
package nsf_pkg;

  localparam int LINE_BUFFER_BYTES_DEF = 128;
  localparam int MAX_FIELDS_DEF        = 32;
  localparam int NAME_SLOTS_DEF        = 4;

  localparam int NAME_W = 40;
  localparam int CFG_W  = 40;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  // End of the sentence ID: the dollar sign plus five ID characters; the ID ends once the fill count reaches ID_END.
  localparam logic [7:0] ID_END = 8'd6;

  localparam logic [2:0] REG_NAMES_IN_USE = 3'd0;
  localparam logic [2:0] REG_NAME_SLOT0   = 3'd1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_MATCH   = 3'd1,
    EV_NOMATCH = 3'd2,
    EV_HDR     = 3'd3,
    EV_ID      = 3'd4,
    EV_CKS     = 3'd5,
    EV_LINE    = 3'd6
  } event_t;

  // Classified input character.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_dollar;
    logic       is_alnum;
    logic       is_star;
    logic       is_cr;
    logic       is_lf;
    logic       is_comma;
    logic       hex_ok;
    logic [3:0] hex_val;
  } cls_t;

  typedef struct packed {
    logic [15:0] good;
    logic [15:0] hdr;
    logic [15:0] id;
    logic [15:0] cks;
    logic [15:0] line;
  } cnt_t;

  typedef struct packed {
    event_t     ev;
    logic [1:0] slot;
    logic [7:0] ch;
    logic       body;
    logic [4:0] field;
    cnt_t       cnt;
  } res_t;

endpackage

FILE: src/nsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_front
// Input side: accepts received bytes and classifies each character before it
// enters the queue to the parser.
// ----------------------------------------------------------------------------
module nsf_front
  import nsf_pkg::*;
(
  input  logic       push,
  input  logic [7:0] rx_byte,
  output logic       full,
  input  logic       q_full,
  output logic       q_push,
  output cls_t       q_data
);

  logic is_digit;
  logic is_upper;
  logic is_lower;
  logic is_hex_letter;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    is_digit      = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    is_upper      = (rx_byte >= CH_UA) && (rx_byte <= CH_UZ);
    is_lower      = (rx_byte >= CH_LA) && (rx_byte <= CH_LZ);
    is_hex_letter = (rx_byte >= CH_UA) && (rx_byte <= CH_UF);

    q_data.ch        = rx_byte;
    q_data.is_dollar = (rx_byte == CH_DOLLAR);
    q_data.is_alnum  = is_digit || is_upper || is_lower;
    q_data.is_star   = (rx_byte == CH_STAR);
    q_data.is_cr     = (rx_byte == CH_CR);
    q_data.is_lf     = (rx_byte == CH_LF);
    q_data.is_comma  = (rx_byte == CH_COMMA);
    q_data.hex_ok    = is_digit || is_hex_letter;
    // Only the low nibble matters: 'A'..'F' map to 10..15 by adding 9.
    if (is_digit) begin
      q_data.hex_val = rx_byte[3:0];
    end else begin
      q_data.hex_val = rx_byte[3:0] + 4'd9;
    end
  end

endmodule

FILE: src/nsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_queue
// Two-entry queue of classified characters between the front and the parser.
// ----------------------------------------------------------------------------
module nsf_queue
  import nsf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t din,
  output logic full,
  input  logic pop,
  output cls_t dout,
  output logic empty
);

  localparam int DEPTH = 2;

  cls_t       mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(DEPTH));
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: src/nsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_back
// Sentence parser: runs the framing state machine over classified characters,
// keeps the checksum, ID and event counters, and holds the result register.
// ----------------------------------------------------------------------------
module nsf_back
  import nsf_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF,
  parameter int MAX_FIELDS        = MAX_FIELDS_DEF,
  parameter int NAME_SLOTS        = NAME_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  cls_t              q_data,
  output logic              q_pop,
  input  logic [2:0]        names_in_use,
  input  logic [NAME_W-1:0] name_slot [NAME_SLOTS],
  output res_t              res,
  output logic              res_valid,
  input  logic              res_pop
);

  localparam logic [7:0] FILL_LIMIT = 8'(LINE_BUFFER_BYTES - 1);
  localparam int         CAP_RAW    = MAX_FIELDS - 1;
  localparam logic [4:0] FIELD_CAP  = 5'((CAP_RAW > 31) ? 31 : CAP_RAW);

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_ID    = 3'd1,
    PH_BODY  = 3'd2,
    PH_CK_HI = 3'd3,
    PH_CK_LO = 3'd4,
    PH_CR    = 3'd5,
    PH_LF    = 3'd6
  } phase_t;

  phase_t            phase, phase_next, ph;
  logic [7:0]        fill_count, fill_next, fc;
  logic [7:0]        computed_xor, xor_next;
  logic [7:0]        received_checksum, ck_next;
  logic [NAME_W-1:0] sentence_id, id_next;
  logic [4:0]        comma_count, comma_next;
  cnt_t              cnt, cnt_next;
  res_t              res_next;

  logic [2:0]        limit;
  logic              hit;
  logic [1:0]        hit_idx;

  assign q_pop = !q_empty && (!res_valid || res_pop);

  // First enabled slot whose name equals the collected ID.
  always_comb begin
    limit = (names_in_use > 3'(NAME_SLOTS)) ? 3'(NAME_SLOTS) : names_in_use;
    hit     = 1'b0;
    hit_idx = 2'd0;
    for (int i = NAME_SLOTS - 1; i >= 0; i--) begin
      if ((3'(i) < limit) && (name_slot[i] == sentence_id)) begin
        hit     = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  always_comb begin
    ph = phase;
    fc = fill_count;
    // Overrun drops the partial sentence without an event.
    if (fill_count >= FILL_LIMIT) begin
      ph = PH_WAIT;
      fc = 8'd0;
    end
    phase_next = ph;
    fill_next  = fc + 8'd1;
    xor_next   = computed_xor;
    ck_next    = received_checksum;
    id_next    = sentence_id;
    comma_next = comma_count;
    cnt_next   = cnt;

    res_next.ev    = EV_NONE;
    res_next.slot  = 2'd0;
    res_next.ch    = q_data.ch;
    res_next.body  = 1'b0;
    res_next.field = 5'd0;

    unique case (ph)
      PH_WAIT: begin
        if (q_data.is_dollar) begin
          phase_next = PH_ID;
          xor_next   = 8'd0;
          ck_next    = 8'd0;
          id_next    = '0;
          comma_next = 5'd0;
        end else begin
          cnt_next.hdr = cnt.hdr + 16'd1;
          res_next.ev  = EV_HDR;
          phase_next   = PH_WAIT;
          fill_next    = 8'd0;
        end
      end
      PH_ID: begin
        if (q_data.is_alnum) begin
          id_next  = {sentence_id[NAME_W-9:0], q_data.ch};
          xor_next = computed_xor ^ q_data.ch;
          if (fill_next >= ID_END) begin
            phase_next = PH_BODY;
          end
        end else begin
          cnt_next.id = cnt.id + 16'd1;
          res_next.ev = EV_ID;
          phase_next  = PH_WAIT;
          fill_next   = 8'd0;
        end
      end
      PH_BODY: begin
        if (q_data.is_star) begin
          phase_next = PH_CK_HI;
        end else if (q_data.is_cr) begin
          // No checksum given: both sides cleared so the sentence passes.
          xor_next   = 8'd0;
          ck_next    = 8'd0;
          phase_next = PH_LF;
        end else begin
          xor_next = computed_xor ^ q_data.ch;
          if (q_data.is_comma && (comma_count < FIELD_CAP)) begin
            comma_next = comma_count + 5'd1;
          end
          res_next.body  = 1'b1;
          res_next.field = comma_next;
        end
      end
      PH_CK_HI, PH_CK_LO: begin
        if (q_data.hex_ok) begin
          if (ph == PH_CK_HI) begin
            ck_next    = {q_data.hex_val, 4'd0};
            phase_next = PH_CK_LO;
          end else begin
            ck_next    = received_checksum + {4'd0, q_data.hex_val};
            phase_next = PH_CR;
          end
        end else begin
          cnt_next.cks = cnt.cks + 16'd1;
          res_next.ev  = EV_CKS;
          phase_next   = PH_WAIT;
          fill_next    = 8'd0;
        end
      end
      PH_CR: begin
        if (q_data.is_cr) begin
          phase_next = PH_LF;
        end else begin
          cnt_next.line = cnt.line + 16'd1;
          res_next.ev   = EV_LINE;
          phase_next    = PH_WAIT;
          fill_next     = 8'd0;
        end
      end
      PH_LF: begin
        if (q_data.is_lf) begin
          if (computed_xor == received_checksum) begin
            cnt_next.good = cnt.good + 16'd1;
            if (hit) begin
              res_next.ev   = EV_MATCH;
              res_next.slot = hit_idx;
            end else begin
              res_next.ev = EV_NOMATCH;
            end
          end else begin
            cnt_next.cks = cnt.cks + 16'd1;
            res_next.ev  = EV_CKS;
          end
        end else begin
          cnt_next.line = cnt.line + 16'd1;
          res_next.ev   = EV_LINE;
        end
        phase_next = PH_WAIT;
        fill_next  = 8'd0;
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
    res_next.cnt = cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      fill_count        <= 8'd0;
      computed_xor      <= 8'd0;
      received_checksum <= 8'd0;
      sentence_id       <= '0;
      comma_count       <= 5'd0;
      cnt               <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (q_pop) begin
        phase             <= phase_next;
        fill_count        <= fill_next;
        computed_xor      <= xor_next;
        received_checksum <= ck_next;
        sentence_id       <= id_next;
        comma_count       <= comma_next;
        cnt               <= cnt_next;
        res_valid         <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

endmodule

FILE: src/nmea_sentence_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core
// Byte-serial NMEA 0183 sentence framer with checksum check, ID matching and
// wrapping event counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive rx_byte and raise push; the item is taken at a clock
//   edge where push is high and full is low.
//   Result channel: every input item gives exactly one result item. It sits on
//   event_res .. line_errors while empty is low and leaves at an edge where pop
//   is high. The counter ports show the counts after that item.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 names in
//   use, 1..4 name slots); write only while no item is in flight.
//   A result passes through the queue and then the result register before it
//   reaches the ports; one item per cycle is sustained while pop stays high. A
//   two-entry queue behind the classifier and the result register keep both
//   sides moving; when pop stays low the parser holds, the queue fills and full
//   rises.
//   Synchronous reset empties the pipeline, returns the parser to waiting for
//   the dollar sign and clears counters and registers.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_core
  import nsf_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF,
  parameter int MAX_FIELDS        = MAX_FIELDS_DEF,
  parameter int NAME_SLOTS        = NAME_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       rx_byte,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       event_res,
  output logic [1:0]       matched_slot,
  output logic [7:0]       data_byte,
  output logic             is_body,
  output logic [4:0]       field_number,
  output logic [15:0]      good_count,
  output logic [15:0]      header_errors,
  output logic [15:0]      id_errors,
  output logic [15:0]      checksum_errors,
  output logic [15:0]      line_errors
);

  logic [2:0]        names_in_use;
  logic [NAME_W-1:0] name_slot [NAME_SLOTS];

  logic q_full;
  logic q_push;
  cls_t q_din;
  logic q_pop;
  cls_t q_dout;
  logic q_empty;
  res_t res;
  logic res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      names_in_use <= 3'd0;
      for (int i = 0; i < NAME_SLOTS; i++) begin
        name_slot[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_NAMES_IN_USE) begin
        names_in_use <= cfg_data[2:0];
      end
      for (int i = 0; i < NAME_SLOTS; i++) begin
        if (cfg_index == REG_NAME_SLOT0 + 3'(i)) begin
          name_slot[i] <= cfg_data[NAME_W-1:0];
        end
      end
    end
  end

  nsf_front u_front (
    .push    (push),
    .rx_byte (rx_byte),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_din)
  );

  nsf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  nsf_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
    .MAX_FIELDS        (MAX_FIELDS),
    .NAME_SLOTS        (NAME_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_dout),
    .q_pop        (q_pop),
    .names_in_use (names_in_use),
    .name_slot    (name_slot),
    .res          (res),
    .res_valid    (res_valid),
    .res_pop      (pop)
  );

  assign empty           = !res_valid;
  assign event_res       = res.ev;
  assign matched_slot    = res.slot;
  assign data_byte       = res.ch;
  assign is_body         = res.body;
  assign field_number    = res.field;
  assign good_count      = res.cnt.good;
  assign header_errors   = res.cnt.hdr;
  assign id_errors       = res.cnt.id;
  assign checksum_errors = res.cnt.cks;
  assign line_errors     = res.cnt.line;

  // Reset leaves nothing waiting on either side.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or queue not empty after reset");

  // A body item never carries a sentence event.
  a_body_no_event: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_body) |-> (event_res == EV_NONE))
    else $error("body item carries an event");

  // Field numbers are only given to body items.
  a_field_body: assert property (@(posedge clk) disable iff (rst)
    (!empty && (field_number != 5'd0)) |-> is_body)
    else $error("field number on a non-body item");

  // The slot stays zero on every item that is not a match.
  a_slot_only_on_match: assert property (@(posedge clk) disable iff (rst)
    (!empty && (event_res != EV_MATCH)) |-> (matched_slot == 2'd0))
    else $error("slot set without a match");

endmodule

FILE: dv/nmea_sentence_framer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core_test
// Self-checking bench for the NMEA sentence framer. A byte-level parser model
// predicts the event, pass-through fields and counters for every byte sent.
// Directed sentences cover framing errors, ID matching and buffer overrun,
// then random sentences run under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_core_test;
  import nsf_pkg::*;

  localparam int LINE_BYTES    = LINE_BUFFER_BYTES_DEF;
  localparam int SLOT_COUNT    = NAME_SLOTS_DEF;
  localparam int FIELD_CAP     = (MAX_FIELDS_DEF - 1 > 31) ? 31 : MAX_FIELDS_DEF - 1;
  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CFG_INDEX_MAX = 7;
  localparam logic [2:0] REG_LAST = REG_NAME_SLOT0 + 3'd3;
  localparam logic [39:0] NAME_ONES = 40'hFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    PH_HUNT, PH_ID, PH_BODY, PH_SUM_HI, PH_SUM_LO, PH_CR, PH_LF
  } frame_phase_t;

  typedef enum int {
    END_SUM, END_NO_SUM, END_BAD_SUM, END_BAD_HEX_HI, END_BAD_HEX_LO,
    END_NO_CR, END_NO_LF, END_CUT
  } ending_t;

  typedef enum int {POP_STEADY, POP_COIN, POP_PATTERN, POP_LONG_STALL} pop_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  event_res;
  logic [1:0]  matched_slot;
  logic [7:0]  data_byte;
  logic        is_body;
  logic [4:0]  field_number;
  logic [15:0] good_count;
  logic [15:0] header_errors;
  logic [15:0] id_errors;
  logic [15:0] checksum_errors;
  logic [15:0] line_errors;

  nmea_sentence_framer_core #(
    .LINE_BUFFER_BYTES(LINE_BYTES),
    .MAX_FIELDS(MAX_FIELDS_DEF),
    .NAME_SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .event_res(event_res),
    .matched_slot(matched_slot),
    .data_byte(data_byte),
    .is_body(is_body),
    .field_number(field_number),
    .good_count(good_count),
    .header_errors(header_errors),
    .id_errors(id_errors),
    .checksum_errors(checksum_errors),
    .line_errors(line_errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Parser model state and its copy of the registers.
  frame_phase_t phase;
  logic [7:0]   byte_count;
  logic [7:0]   xor_acc;
  logic [7:0]   sum_rx;
  logic [39:0]  id_shift;
  logic [4:0]   commas;
  cnt_t         counts;
  logic [2:0]   names_on;
  logic [39:0]  slot_names [SLOT_COUNT];

  res_t       parse_results_q [$];
  logic [7:0] body_q [$];
  int         fail_count;
  int         items_sent;
  int         burst_left;
  int         overruns;
  int         settings_done;
  int         ev_tally [7];
  int         cycles;

  function automatic bit is_id_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF);
  endfunction

  function automatic void rewind();
    phase      = PH_HUNT;
    byte_count = 8'd0;
  endfunction

  function automatic void clear_parser();
    phase      = PH_HUNT;
    byte_count = 8'd0;
    xor_acc    = 8'd0;
    sum_rx     = 8'd0;
    id_shift   = 40'd0;
    commas     = 5'd0;
    counts     = '0;
    names_on   = 3'd0;
    for (int i = 0; i < SLOT_COUNT; i++) slot_names[i] = 40'd0;
  endfunction

  // Advances the parser model by one received byte and returns its result.
  function automatic res_t parse_byte(input logic [7:0] ch);
    res_t       r;
    logic [3:0] nib;
    int         lim;
    r    = '0;
    r.ev = EV_NONE;
    r.ch = ch;
    if (byte_count >= 8'(LINE_BYTES - 1)) begin
      rewind();
      overruns++;
    end
    byte_count = byte_count + 8'd1;
    nib = (ch <= CH_NINE) ? 4'(ch - CH_ZERO) : 4'(ch - CH_UA + 8'd10);
    case (phase)
      PH_HUNT: begin
        if (ch == CH_DOLLAR) begin
          phase    = PH_ID;
          xor_acc  = 8'd0;
          sum_rx   = 8'd0;
          id_shift = 40'd0;
          commas   = 5'd0;
        end else begin
          counts.hdr += 16'd1;
          r.ev = EV_HDR;
          rewind();
        end
      end
      PH_ID: begin
        if (is_id_char(ch)) begin
          id_shift = {id_shift[31:0], ch};
          xor_acc ^= ch;
          if (byte_count >= ID_END) phase = PH_BODY;
        end else begin
          counts.id += 16'd1;
          r.ev = EV_ID;
          rewind();
        end
      end
      PH_BODY: begin
        if (ch == CH_STAR) begin
          phase = PH_SUM_HI;
        end else if (ch == CH_CR) begin
          // Without a checksum both sums are cleared, so LF always accepts.
          xor_acc = 8'd0;
          sum_rx  = 8'd0;
          phase   = PH_LF;
        end else begin
          xor_acc ^= ch;
          if (ch == CH_COMMA && commas < 5'(FIELD_CAP)) commas = commas + 5'd1;
          r.body  = 1'b1;
          r.field = commas;
        end
      end
      PH_SUM_HI, PH_SUM_LO: begin
        if (!is_hex_char(ch)) begin
          counts.cks += 16'd1;
          r.ev = EV_CKS;
          rewind();
        end else if (phase == PH_SUM_HI) begin
          sum_rx = {nib, 4'h0};
          phase  = PH_SUM_LO;
        end else begin
          sum_rx = sum_rx + {4'h0, nib};
          phase  = PH_CR;
        end
      end
      PH_CR: begin
        if (ch == CH_CR) begin
          phase = PH_LF;
        end else begin
          counts.line += 16'd1;
          r.ev = EV_LINE;
          rewind();
        end
      end
      PH_LF: begin
        if (ch != CH_LF) begin
          counts.line += 16'd1;
          r.ev = EV_LINE;
        end else if (xor_acc != sum_rx) begin
          counts.cks += 16'd1;
          r.ev = EV_CKS;
        end else begin
          counts.good += 16'd1;
          r.ev = EV_NOMATCH;
          lim = (names_on > SLOT_COUNT) ? SLOT_COUNT : int'(names_on);
          // Scanning downward leaves the lowest matching slot in place.
          for (int i = lim - 1; i >= 0; i--) begin
            if (slot_names[i] == id_shift) begin
              r.ev   = EV_MATCH;
              r.slot = 2'(i);
            end
          end
        end
        rewind();
      end
      default: phase = PH_HUNT;
    endcase
    r.cnt = counts;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [39:0] want,
                                      input logic [39:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (parse_results_q.size() == 0) begin
        $error("result with nothing outstanding: data_byte %0h", data_byte);
        fail_count++;
      end else begin
        want = parse_results_q.pop_front();
        check_field("event_res", want.ev, event_res);
        check_field("matched_slot", want.slot, matched_slot);
        check_field("data_byte", want.ch, data_byte);
        check_field("is_body", want.body, is_body);
        check_field("field_number", want.field, field_number);
        check_field("good_count", want.cnt.good, good_count);
        check_field("header_errors", want.cnt.hdr, header_errors);
        check_field("id_errors", want.cnt.id, id_errors);
        check_field("checksum_errors", want.cnt.cks, checksum_errors);
        check_field("line_errors", want.cnt.line, line_errors);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               parse_results_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: switches between steady draining, coin flips, a fixed pattern
  // and long stalls that back the queue up into full.
  pop_style_t pop_style;
  int         style_left;
  int         stall_left;

  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      pop_style  <= POP_STEADY;
      style_left <= 0;
      stall_left <= 0;
    end else begin
      if (style_left == 0) begin
        pop_style  <= pop_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(50, 300);
      end else begin
        style_left <= style_left - 1;
      end
      case (pop_style)
        POP_STEADY: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_PATTERN: pop <= (cycles % 7 != 2) && (cycles % 7 != 3);
        default: begin
          if (stall_left == 0) begin
            pop        <= !pop;
            stall_left <= pop ? $urandom_range(10, 30) : $urandom_range(1, 8);
          end else begin
            stall_left <= stall_left - 1;
          end
        end
      endcase
    end
  end

  function automatic logic [39:0] pool_name(input int k);
    case (k % 8)
      0: return "GPGGA";
      1: return "GPRMC";
      2: return "GNGSA";
      3: return "GPVTG";
      4: return "GLGSV";
      5: return "BDGSV";
      6: return "GPZDA";
      default: return "GPGLL";
    endcase
  endfunction

  function automatic logic [7:0] any_id_char();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_UA + 8'(r - 10);
    return CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] non_id_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_id_char(c));
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return CH_LA + 8'($urandom_range(0, 5));
    do c = 8'($urandom_range(0, 255)); while (is_hex_char(c));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + 8'(v) : CH_UA + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] c);
    logic [7:0] x;
    x = 8'($urandom_range(0, 255));
    return (x == c) ? ~c : x;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int   gap;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    r = parse_byte(b);
    ev_tally[r.ev]++;
    parse_results_q.push_back(r);
    burst_left--;
    items_sent++;
  endtask

  // Holds input until every outstanding byte has come back, then lets the
  // pipeline settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_NAMES_IN_USE) names_on = val[2:0];
    else if (idx <= REG_LAST) slot_names[idx - REG_NAME_SLOT0] = val;
  endtask

  task automatic configure(input logic [39:0] use_word, input logic [39:0] n0,
                           input logic [39:0] n1, input logic [39:0] n2,
                           input logic [39:0] n3, input bit stray_writes);
    wait_idle();
    write_reg(REG_NAMES_IN_USE, use_word);
    write_reg(REG_NAME_SLOT0, n0);
    write_reg(REG_NAME_SLOT0 + 3'd1, n1);
    write_reg(REG_NAME_SLOT0 + 3'd2, n2);
    write_reg(REG_LAST, n3);
    if (stray_writes) begin
      for (int idx = int'(REG_LAST) + 1; idx <= CFG_INDEX_MAX; idx++)
        write_reg(3'(idx), 40'({$urandom, $urandom}));
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic load_text(input string s);
    body_q.delete();
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic fill_body(input int len, input bit plain);
    int pick;
    logic [7:0] c;
    body_q.delete();
    repeat (len) begin
      pick = $urandom_range(0, 19);
      if (plain || pick < 8) c = any_id_char();
      else if (pick < 15) c = CH_COMMA;
      else c = 8'($urandom_range(0, 255));
      if (c == CH_STAR || c == CH_CR) c = CH_COMMA;
      body_q.push_back(c);
    end
  endtask

  // Sends '$', the ID, body_q and the chosen ending.
  task automatic send_framed(input logic [39:0] id, input ending_t ending);
    logic [7:0] sum;
    sum = 8'h00;
    send_byte(CH_DOLLAR);
    for (int i = 4; i >= 0; i--) begin
      send_byte(id[i*8 +: 8]);
      sum ^= id[i*8 +: 8];
    end
    foreach (body_q[k]) begin
      send_byte(body_q[k]);
      sum ^= body_q[k];
    end
    if (ending == END_CUT) return;
    if (ending != END_NO_SUM && ending != END_NO_LF) begin
      if (ending == END_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
      send_byte(CH_STAR);
      send_byte(ending == END_BAD_HEX_HI ? non_hex_char() : hex_char(sum[7:4]));
      if (ending == END_BAD_HEX_HI) return;
      send_byte(ending == END_BAD_HEX_LO ? non_hex_char() : hex_char(sum[3:0]));
      if (ending == END_BAD_HEX_LO) return;
      if (ending == END_NO_CR) begin
        send_byte(other_than(CH_CR));
        return;
      end
    end
    send_byte(CH_CR);
    send_byte(ending == END_NO_LF ? other_than(CH_LF) : CH_LF);
  endtask

  task automatic test_directed_cases();
    configure(40'd4, pool_name(0), pool_name(1), pool_name(0), NAME_ONES, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    load_text(",1,");
    send_framed(pool_name(0), END_SUM);
    body_q.delete();
    send_framed(pool_name(1), END_NO_SUM);
    body_q = '{8'h00, 8'hFF, CH_COMMA};
    send_framed("ZZ9az", END_BAD_SUM);
    // A lower-case hex digit is not accepted.
    body_q.delete();
    send_framed(pool_name(2), END_CUT);
    send_byte(CH_STAR);
    send_byte("c");
    send_framed(pool_name(3), END_NO_CR);
    send_framed(pool_name(3), END_NO_LF);
    send_framed({"GP", 8'h2D, "AB"}, END_SUM);
  endtask

  task automatic test_name_matching();
    logic [36:0] upper;
    for (int nu = 0; nu <= CFG_INDEX_MAX; nu++) begin
      upper = (nu % 2 == 1) ? 37'({$urandom, $urandom}) : 37'd0;
      // Slot 3 repeats slot 1, so a hit there must report slot 1.
      configure({upper, 3'(nu)}, pool_name(nu), pool_name(nu + 1), pool_name(nu + 2),
                pool_name(nu + 1), 1'b0);
      for (int k = 0; k < SLOT_COUNT; k++) begin
        load_text(",");
        send_framed(slot_names[k], (k % 2 == 1) ? END_NO_SUM : END_SUM);
      end
      body_q.delete();
      send_framed(pool_name(nu + 5), END_SUM);
    end
  endtask

  task automatic test_overrun_and_fields();
    configure(40'd2, pool_name(0), pool_name(1), 40'd0, NAME_ONES, 1'b0);
    // More commas than fields: the field number saturates.
    body_q.delete();
    repeat (100) body_q.push_back(CH_COMMA);
    send_framed(pool_name(0), END_SUM);
    // The LF lands on the last byte that fits, then one byte too far.
    fill_body(LINE_BYTES - 9, 1'b1);
    send_framed(pool_name(1), END_NO_SUM);
    fill_body(LINE_BYTES - 8, 1'b1);
    send_framed(pool_name(1), END_NO_SUM);
    // The dollar sign that overruns starts the next sentence.
    fill_body(LINE_BYTES - 7, 1'b1);
    send_framed(pool_name(2), END_CUT);
    body_q.delete();
    send_framed(pool_name(1), END_SUM);
    fill_body(LINE_BYTES + 12, 1'b0);
    send_framed(pool_name(0), END_SUM);
  endtask

  task automatic send_random_sentence();
    int          pick;
    int          len;
    int          pos;
    logic [39:0] id;
    ending_t     ending;
    if ($urandom_range(0, 11) == 0)
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 19);
    if (pick < 9) begin
      id = slot_names[$urandom_range(0, SLOT_COUNT - 1)];
    end else if (pick < 14) begin
      id = pool_name($urandom_range(0, 7));
    end else begin
      for (int i = 0; i < 5; i++) id[i*8 +: 8] = any_id_char();
      if (pick >= 18) begin
        pos = $urandom_range(0, 4);
        id[pos*8 +: 8] = non_id_char();
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) len = $urandom_range(0, 16);
    else if (pick < 97) len = $urandom_range(17, 60);
    else len = $urandom_range(100, LINE_BYTES + 12);
    fill_body(len, 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 50) ending = END_SUM;
    else if (pick < 62) ending = END_NO_SUM;
    else if (pick < 70) ending = END_BAD_SUM;
    else if (pick < 75) ending = END_BAD_HEX_HI;
    else if (pick < 80) ending = END_BAD_HEX_LO;
    else if (pick < 87) ending = END_NO_CR;
    else if (pick < 94) ending = END_NO_LF;
    else ending = END_CUT;
    send_framed(id, ending);
  endtask

  task automatic random_slot_name(output logic [39:0] name);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) name = pool_name($urandom_range(0, 7));
    else if (pick == 7) name = 40'd0;
    else if (pick == 8) name = NAME_ONES;
    else name = 40'({$urandom, $urandom});
  endtask

  // Random sentences top the run up to the overall item count.
  task automatic test_random_traffic();
    int          next_cfg;
    logic [39:0] n [4];
    logic [2:0]  nu;
    next_cfg = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_cfg) begin
        for (int k = 0; k < 4; k++) random_slot_name(n[k]);
        nu = ($urandom_range(0, 1) == 0) ? 3'(SLOT_COUNT) : 3'($urandom_range(0, 7));
        configure({37'($urandom_range(0, 1) == 0 ? 0 : {$urandom, $urandom}), nu},
                  n[0], n[1], n[2], n[3], $urandom_range(0, 3) == 0);
        next_cfg = items_sent + 200;
      end
      send_random_sentence();
    end
  endtask

  initial begin
    int drain;
    fail_count    = 0;
    items_sent    = 0;
    burst_left    = 0;
    overruns      = 0;
    settings_done = 0;
    cycles        = 0;
    for (int i = 0; i < 7; i++) ev_tally[i] = 0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_name_matching();
    test_overrun_and_fields();
    test_random_traffic();

    push <= 1'b0;
    for (drain = 0; drain < DRAIN_LIMIT && parse_results_q.size() != 0; drain++)
      @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (parse_results_q.size() != 0) begin
      $error("%0d results never arrived", parse_results_q.size());
      fail_count += parse_results_q.size();
    end

    $display("Framed %0d bytes under %0d register settings, %0d buffer overruns.",
             items_sent, settings_done, overruns);
    $display("Events: %0d matched, %0d unmatched, %0d header, %0d id, %0d checksum, %0d line.",
             ev_tally[EV_MATCH], ev_tally[EV_NOMATCH], ev_tally[EV_HDR], ev_tally[EV_ID],
             ev_tally[EV_CKS], ev_tally[EV_LINE]);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
